// File: hdl/tta_pkg.sv
// Shared constants, types and the resistance table for the thermistor averager.
// No dependencies; imported by every module of the block except tta_ram.
`timescale 1ns / 1ps

package tta_pkg;

    localparam int HISTORY_DEPTH = 30;
    localparam int TABLE_DEPTH   = 100;
    localparam int ROM_ENTRIES   = 100;
    localparam int SCAN_LIMIT    = (TABLE_DEPTH < ROM_ENTRIES) ? TABLE_DEPTH : ROM_ENTRIES;

    // fixed field widths
    localparam int CODE_W = 12;
    localparam int TEMP_W = 7;
    localparam int SAMP_W = 5;

    localparam int IDX_W  = (SCAN_LIMIT > 1) ? $clog2(SCAN_LIMIT) : 1;
    localparam int ROM_AW = $clog2(ROM_ENTRIES);
    localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = $clog2(HISTORY_DEPTH * (SCAN_LIMIT - 1) + 1);

    // divider resistance test: entry * (LHS_BASE - LHS_SLOPE*code) < RHS_SLOPE*code
    localparam int ROM_W     = 11;
    localparam int LHS_W     = 18;
    localparam int RHS_W     = 26;
    localparam int PROD_W    = ROM_W + LHS_W;
    localparam int LHS_BASE  = 204800;
    localparam int LHS_SLOPE = 33;
    localparam int RHS_SLOPE = 15510;

    // resistance in tenths of a kilo-ohm, one entry per degree, descending
    localparam logic [ROM_W-1:0] RES_ROM [ROM_ENTRIES] = '{
        11'd1623, 11'd1543, 11'd1467, 11'd1396, 11'd1328,
        11'd1264, 11'd1204, 11'd1147, 11'd1093, 11'd1041,
        11'd993,  11'd946,  11'd903,  11'd861,  11'd822,
        11'd785,  11'd749,  11'd716,  11'd684,  11'd653,
        11'd624,  11'd597,  11'd571,  11'd546,  11'd522,
        11'd500,  11'd479,  11'd458,  11'd439,  11'd420,
        11'd403,  11'd386,  11'd370,  11'd355,  11'd340,
        11'd326,  11'd313,  11'd301,  11'd289,  11'd277,
        11'd266,  11'd256,  11'd245,  11'd236,  11'd227,
        11'd218,  11'd210,  11'd201,  11'd194,  11'd186,
        11'd179,  11'd173,  11'd166,  11'd160,  11'd154,
        11'd148,  11'd143,  11'd138,  11'd133,  11'd128,
        11'd123,  11'd119,  11'd115,  11'd111,  11'd107,
        11'd103,  11'd99,   11'd96,   11'd93,   11'd89,
        11'd86,   11'd83,   11'd81,   11'd79,   11'd75,
        11'd73,   11'd70,   11'd68,   11'd66,   11'd63,
        11'd61,   11'd59,   11'd57,   11'd56,   11'd54,
        11'd52,   11'd50,   11'd49,   11'd47,   11'd46,
        11'd44,   11'd43,   11'd42,   11'd40,   11'd39,
        11'd38,   11'd37,   11'd36,   11'd35,   11'd33
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

endpackage

// File: hdl/tta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tta_div.sv
// Restoring divider: one quotient bit per cycle, history sum by sample count.
// Depends on tta_pkg.
`timescale 1ns / 1ps

module tta_div
    import tta_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [TEMP_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    rem_sh;
    logic              fits;
    logic [CNT_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[SUM_W-1]};
        fits    = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the top bit drops away
            r_rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = TEMP_W'(r_quo);

endmodule

// File: hdl/thermistor_table_temp_averager.sv
// Thermistor ADC code to averaged table temperature: sequencer, table scan, history.
// Depends on tta_pkg, tta_ram and tta_div.
`timescale 1ns / 1ps

// Each accepted ADC code is compared against the resistance table one entry per
// cycle through a single multiply-compare unit, stopping at the first entry below
// the divider resistance; that index is the temperature. It goes into a 30-entry
// history ring whose running sum is divided by the fill count with a one-bit-per-
// cycle divider. The input reopens in the cycle the result appears, so the next
// transfer can be taken in that same cycle. A code that matches no entry yields no
// result and frees the block after the full scan. The input is stalled for the
// whole time an item is in work. The result is held in an output register, so it
// may wait while the next code is processed.

module thermistor_table_temp_averager
    import tta_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CODE_W-1:0] i_adc_code,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [TEMP_W-1:0] o_temperature,
    output logic [SAMP_W-1:0] o_samples_averaged
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [LHS_W-1:0]  r_lhs;
    logic [RHS_W-1:0]  r_rhs;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic              r_out_valid, n_out_valid;
    logic [TEMP_W-1:0] r_temp;
    logic [SAMP_W-1:0] r_samp;

    logic              in_xfer;
    logic              out_free;
    logic              load_out;
    logic              ram_we;
    logic [TEMP_W-1:0] ram_rdata;
    logic [PROD_W-1:0] product;
    logic              hit;
    logic              full;
    logic              div_done;
    logic [TEMP_W-1:0] div_quo;
    t_div_req          div_req;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign full     = (r_count == CNT_W'(HISTORY_DEPTH));

    // shared multiply-compare unit for the table scan
    always_comb begin
        product = PROD_W'(RES_ROM[ROM_AW'(r_idx)]) * PROD_W'(r_lhs);
        hit     = (product < PROD_W'(r_rhs));
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_count  = r_count;
        n_wptr   = r_wptr;
        ram_we   = 1'b0;
        load_out = 1'b0;
        div_req  = '{start: 1'b0, dividend: r_sum, divisor: r_count};

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_state = ST_READ;
                end else if (r_idx == IDX_W'(SCAN_LIMIT - 1)) begin
                    // no entry qualifies: drop the item
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_READ: begin
                // oldest entry sits in the slot about to be overwritten
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                ram_we  = 1'b1;
                n_sum   = r_sum + SUM_W'(r_idx) - (full ? SUM_W'(ram_rdata) : SUM_W'(0));
                n_count = full ? r_count : r_count + CNT_W'(1);
                n_wptr  = (r_wptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
                div_req = '{start: 1'b1, dividend: n_sum, divisor: n_count};
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_wptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_wptr      <= n_wptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (in_xfer) begin
            r_lhs <= LHS_W'(LHS_BASE) - LHS_W'(i_adc_code) * LHS_W'(LHS_SLOPE);
            r_rhs <= RHS_W'(i_adc_code) * RHS_W'(RHS_SLOPE);
        end
        if (load_out) begin
            r_temp <= div_quo;
            r_samp <= SAMP_W'(r_count);
        end
    end

    tta_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (TEMP_W'(r_idx)),
        .i_raddr (r_wptr),
        .o_rdata (ram_rdata)
    );

    tta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_in_stall         = (r_state != ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_temperature      = r_temp;
    assign o_samples_averaged = r_samp;

endmodule

// File: hdl/tta_checker.sv
// Port-level checks on the thermistor averager, attached by bind.
// Depends on tta_pkg and thermistor_table_temp_averager.
`timescale 1ns / 1ps

module tta_checker
    import tta_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [CODE_W-1:0] i_adc_code,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [TEMP_W-1:0] o_temperature,
    input logic [SAMP_W-1:0] o_samples_averaged
);

    // a transfer always starts a scan, so the input closes next cycle
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_adc_code)))
        else $error("stalled input code changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_temperature)
            && $stable(o_samples_averaged)))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_samples_averaged != '0)
            && (o_samples_averaged <= SAMP_W'(HISTORY_DEPTH)))
        else $error("sample count out of range");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temperature <= TEMP_W'(SCAN_LIMIT - 1)))
        else $error("temperature beyond table");

endmodule

bind thermistor_table_temp_averager tta_checker u_tta_checker (.*);
